// ----- hw/rtl/call_stack_exclusive_time_macros.svh -----
// Assertion macros for the call-stack exclusive-time profiler.
// Used by the datapath module; expects clk_i and rst_ni in scope.
`ifndef CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH
`define CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked only out of reset
`define CSET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every edge, reset included
`define CSET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CSET_ASSERT(lbl, prop, msg)
`define CSET_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/cset_pkg.sv -----
// Shared types and constants for the call-stack exclusive-time profiler.
// No dependencies; imported by the controller, datapath and top level.
package cset_pkg;

  localparam int TIME_WIDTH      = 32;
  localparam int ID_WIDTH        = 6;
  localparam int CNT_WIDTH       = 7;
  localparam int TDATA_WIDTH     = 40;
  localparam int DEF_MAX_FUNCS   = 64;
  localparam int DEF_STACK_DEPTH = 64;
  localparam logic [CNT_WIDTH-1:0] FCOUNT_RESET = 7'd64;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DUR,
    ST_EXCL,
    ST_COMMIT,
    ST_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic check;
    logic push;
    logic dur;
    logic excl;
    logic commit;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_done;
    logic err;
    logic is_enter;
    logic out_free;
  } sts_t;

endpackage

// ----- hw/rtl/cset_ctrl.sv -----
// Sequencing state machine of the profiler.
// Depends on cset_pkg; drives the datapath through cmd_t, reads sts_t.
module cset_ctrl
  import cset_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (sts_i.err) begin
          state_d = ST_RESULT;
        end else if (sts_i.is_enter) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          state_d = ST_DUR;
        end
      end
      ST_DUR: begin
        cmd_o.dur = 1'b1;
        state_d   = ST_EXCL;
      end
      ST_EXCL: begin
        cmd_o.excl = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

// ----- hw/rtl/cset_dpath.sv -----
// Datapath of the profiler: stack memories, totals memory, level counter,
// saturating arithmetic and output register. Depends on cset_pkg and the macro header.
`include "call_stack_exclusive_time_macros.svh"
module cset_dpath
  import cset_pkg::*;
#(
  parameter int MAX_FUNCS   = DEF_MAX_FUNCS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [CNT_WIDTH-1:0]  cfg_wdata_i,
  input  logic                  in_kind_i,
  input  logic [ID_WIDTH-1:0]   in_func_i,
  input  logic [TIME_WIDTH-1:0] in_time_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [ID_WIDTH-1:0]   out_func_o,
  output logic [TIME_WIDTH-1:0] out_total_o,
  output status_e               out_status_o
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int FW = $clog2(MAX_FUNCS);
  localparam int XW = (FW > ID_WIDTH) ? FW : ID_WIDTH;
  localparam logic [TIME_WIDTH-1:0] TMAX = '1;

  // configuration and control state
  logic [CNT_WIDTH-1:0] fcount_q;
  logic [LW-1:0]        level_q, level_d;
  logic [FW-1:0]        clr_q;
  logic                 out_valid_q;

  // per-transaction payload
  logic                  kind_q;
  logic [ID_WIDTH-1:0]   id_q;
  logic [TIME_WIDTH-1:0] ts_q;
  logic [TIME_WIDTH:0]   ts1_q;
  status_e               status_q, status_d;
  logic [TIME_WIDTH-1:0] dur_q, dur_d;
  logic [TIME_WIDTH-1:0] excl_q, excl_d;
  logic [TIME_WIDTH-1:0] parent_q, parent_d;
  logic [TIME_WIDTH-1:0] total_q, total_d;
  logic [ID_WIDTH-1:0]   res_func_q;
  logic [TIME_WIDTH-1:0] res_total_q;
  status_e               res_status_q;

  // memories
  logic [TIME_WIDTH-1:0] start_mem [STACK_DEPTH];
  logic [TIME_WIDTH-1:0] child_mem [STACK_DEPTH+1];
  logic [TIME_WIDTH-1:0] tot_mem   [MAX_FUNCS];
  logic [TIME_WIDTH-1:0] start_rd_q, child_rd_q, parent_rd_q, tot_rd_q;

  logic [XW-1:0] id_ext;
  logic [FW-1:0] id_addr;
  logic [LW-1:0] level_dec;
  logic          range_err;

  assign id_ext    = XW'(id_q);
  assign id_addr   = id_ext[FW-1:0];
  assign level_dec = level_q - LW'(1);

  assign range_err = ({1'b0, id_q} >= fcount_q) || (32'(id_q) >= 32'(MAX_FUNCS));

  always_comb begin
    if (range_err) begin
      status_d = STATUS_RANGE;
    end else if (!kind_q) begin
      status_d = (level_q == LW'(STACK_DEPTH)) ? STATUS_OVERFLOW : STATUS_OK;
    end else begin
      status_d = (level_q == '0) ? STATUS_UNDERFLOW : STATUS_OK;
    end
  end

  assign sts_o.clear_done = (clr_q == FW'(MAX_FUNCS - 1));
  assign sts_o.err        = (status_d != STATUS_OK);
  assign sts_o.is_enter   = !kind_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // duration = (ts + 1) - start, zero when end precedes start, capped at max
  logic [TIME_WIDTH+1:0] diff;
  assign diff = {1'b0, ts1_q} - {2'b00, start_rd_q};
  always_comb begin
    if (diff[TIME_WIDTH+1] || (diff == '0)) begin
      dur_d = '0;
    end else if (diff[TIME_WIDTH]) begin
      dur_d = TMAX;
    end else begin
      dur_d = diff[TIME_WIDTH-1:0];
    end
  end

  logic [TIME_WIDTH:0] excl_sub, parent_sum, total_sum;
  assign excl_sub   = {1'b0, dur_q} - {1'b0, child_rd_q};
  assign excl_d     = excl_sub[TIME_WIDTH] ? '0 : excl_sub[TIME_WIDTH-1:0];
  assign parent_sum = {1'b0, parent_rd_q} + {1'b0, dur_q};
  assign parent_d   = parent_sum[TIME_WIDTH] ? TMAX : parent_sum[TIME_WIDTH-1:0];
  assign total_sum  = {1'b0, tot_rd_q} + {1'b0, excl_q};
  assign total_d    = total_sum[TIME_WIDTH] ? TMAX : total_sum[TIME_WIDTH-1:0];

  always_comb begin
    level_d = level_q;
    if (cmd_i.push) begin
      level_d = level_q + LW'(1);
    end else if (cmd_i.commit) begin
      level_d = level_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcount_q    <= FCOUNT_RESET;
      level_q     <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fcount_q <= cfg_wdata_i;
      end
      level_q <= level_d;
      if (cmd_i.clear && !sts_o.clear_done) begin
        clr_q <= clr_q + FW'(1);
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= in_kind_i;
      id_q   <= in_func_i;
      ts_q   <= in_time_i;
    end
    if (cmd_i.check) begin
      status_q <= status_d;
      ts1_q    <= {1'b0, ts_q} + {{TIME_WIDTH{1'b0}}, 1'b1};
    end
    if (cmd_i.dur) begin
      dur_q <= dur_d;
    end
    if (cmd_i.excl) begin
      excl_q   <= excl_d;
      parent_q <= parent_d;
    end
    if (cmd_i.commit) begin
      total_q <= total_d;
    end
    if (cmd_i.load_out) begin
      res_func_q   <= id_q;
      res_total_q  <= (status_q == STATUS_OK) ? total_q : '0;
      res_status_q <= status_q;
    end
  end

  // start times: written on enter, read at the top frame
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      start_mem[level_q[SW-1:0]] <= ts_q;
    end
    start_rd_q <= start_mem[level_dec[SW-1:0]];
  end

  // child times: root entry zeroed by the clear pass, new frame zeroed on enter,
  // parent accumulates on exit
  logic                  child_we;
  logic [LW-1:0]         child_waddr;
  logic [TIME_WIDTH-1:0] child_wdata;
  always_comb begin
    child_we    = cmd_i.clear || cmd_i.push || cmd_i.commit;
    child_waddr = '0;
    child_wdata = '0;
    if (cmd_i.push) begin
      child_waddr = level_q + LW'(1);
    end else if (cmd_i.commit) begin
      child_waddr = level_dec;
      child_wdata = parent_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    child_rd_q  <= child_mem[level_q];
    parent_rd_q <= child_mem[level_dec];
  end

  // exclusive totals, swept to zero after reset
  logic                  tot_we;
  logic [FW-1:0]         tot_waddr;
  logic [TIME_WIDTH-1:0] tot_wdata;
  always_comb begin
    tot_we    = cmd_i.clear || cmd_i.commit;
    tot_waddr = cmd_i.clear ? clr_q : id_addr;
    tot_wdata = cmd_i.clear ? '0 : total_d;
  end

  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    tot_rd_q <= tot_mem[id_addr];
  end

  assign out_valid_o  = out_valid_q;
  assign out_func_o   = res_func_q;
  assign out_total_o  = res_total_q;
  assign out_status_o = res_status_q;

  `CSET_ASSERT(a_level_bound, level_q <= LW'(STACK_DEPTH), "stack level beyond depth")
  `CSET_ASSERT(a_push_inc, cmd_i.push |=> (level_q == $past(level_q) + LW'(1)), "push did not raise level")
  `CSET_ASSERT(a_pop_dec, cmd_i.commit |=> (level_q == $past(level_q) - LW'(1)), "exit did not lower level")
  `CSET_ASSERT(a_err_zero, (cmd_i.load_out && (status_q != STATUS_OK)) |=> (out_total_o == '0), "error result carries nonzero total")
  `CSET_ASSERT_ALWAYS(a_no_push_commit, !(cmd_i.push && cmd_i.commit), "push and exit in one cycle")

endmodule

// ----- hw/rtl/call_stack_exclusive_time.sv -----
// Exclusive-time profiler over a stream of function enter/exit events. After reset the block
// runs a clearing pass over every entry of the totals memory before it takes any event.
// An event is then handled one at a time by a sequencer: an enter passes the check state and
// returns to idle, an error goes from check to result hand-off, and an exit runs memory read,
// duration, exclusive part and parent sum, saturating total update and result hand-off; the exit
// steps follow from the registered memory reads and the chain of saturating 32-bit adds. A
// finished result sits in an output register, so one result may wait while the next event is
// taken. Each exit or error returns the function id, its updated exclusive total (zero on error)
// and a status code. Depends on cset_pkg, cset_ctrl and cset_dpath.
module call_stack_exclusive_time
  import cset_pkg::*;
#(
  parameter int MAX_FUNCS   = DEF_MAX_FUNCS,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_WIDTH-1:0]   cfg_wdata_i,    // function_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_WIDTH-1:0] s_axis_tdata,   // [5:0] func_id, [37:6] timestamp, pad
  input  logic [0:0]             s_axis_tuser,   // [0] kind: 0 enter, 1 exit
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_WIDTH-1:0] m_axis_tdata,   // [5:0] result_func, [37:6] exclusive_total
  output logic [1:0]             m_axis_tuser    // [1:0] status
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [ID_WIDTH-1:0]   out_func;
  logic [TIME_WIDTH-1:0] out_total;
  status_e               out_status;

  cset_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cset_dpath #(
    .MAX_FUNCS   (MAX_FUNCS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_kind_i    (s_axis_tuser[0]),
    .in_func_i    (s_axis_tdata[ID_WIDTH-1:0]),
    .in_time_i    (s_axis_tdata[ID_WIDTH+TIME_WIDTH-1:ID_WIDTH]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_func_o   (out_func),
    .out_total_o  (out_total),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {{(TDATA_WIDTH - ID_WIDTH - TIME_WIDTH){1'b0}}, out_total, out_func};
  assign m_axis_tuser = out_status;

endmodule

// ----- tb/cset_tb_pkg.sv -----
// Event and report types shared by the profiler testbench and its checker.
// Depends on cset_pkg for widths and status codes.
package cset_tb_pkg;
  import cset_pkg::*;

  typedef enum logic {
    EV_ENTER = 1'b0,
    EV_EXIT  = 1'b1
  } event_kind_e;

  typedef struct packed {
    logic [ID_WIDTH-1:0]   func;
    logic [TIME_WIDTH-1:0] total;
    status_e               status;
  } profile_report_t;

endpackage

// ----- tb/call_stack_exclusive_time_checker.sv -----
// Passive checker for call_stack_exclusive_time: tracks the call stack and per-function
// exclusive totals from accepted events and compares every result transaction.
// Depends on cset_pkg and cset_tb_pkg.
module call_stack_exclusive_time_checker
  import cset_pkg::*;
  import cset_tb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CNT_WIDTH-1:0]   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [TDATA_WIDTH-1:0] s_axis_tdata,   // [5:0] func_id, [37:6] timestamp, pad
  input  logic [0:0]             s_axis_tuser,   // [0] kind
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_WIDTH-1:0] m_axis_tdata,   // [5:0] result_func, [37:6] exclusive_total
  input  logic [1:0]             m_axis_tuser,   // [1:0] status
  output int                     fail_count_o,
  output int                     owed_count_o
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic [CNT_WIDTH-1:0]  func_count;
  logic [TIME_WIDTH-1:0] frame_start [DEF_STACK_DEPTH];
  logic [TIME_WIDTH-1:0] child_time  [DEF_STACK_DEPTH+1];
  logic [TIME_WIDTH-1:0] excl_total  [DEF_MAX_FUNCS];
  int unsigned           depth;
  profile_report_t       owed_reports [$];

  function automatic logic [TIME_WIDTH-1:0] sat_sum(input logic [TIME_WIDTH-1:0] a,
                                                    input logic [TIME_WIDTH-1:0] b);
    logic [TIME_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_WIDTH] ? TIME_MAX : s[TIME_WIDTH-1:0];
  endfunction

  // Applies one event to the stack/totals; returns 1 when the event produces a report.
  function automatic bit account_event(input event_kind_e kind,
                                       input logic [ID_WIDTH-1:0] id,
                                       input logic [TIME_WIDTH-1:0] ts,
                                       output profile_report_t rep);
    logic [TIME_WIDTH-1:0] dur;
    logic [TIME_WIDTH-1:0] excl;
    rep.func   = id;
    rep.total  = '0;
    rep.status = STATUS_OK;
    if (int'(id) >= int'(func_count) || int'(id) >= DEF_MAX_FUNCS) begin
      rep.status = STATUS_RANGE;
      return 1'b1;
    end
    if (kind == EV_ENTER) begin
      if (depth >= DEF_STACK_DEPTH) begin
        rep.status = STATUS_OVERFLOW;
        return 1'b1;
      end
      frame_start[depth] = ts;
      depth++;
      child_time[depth] = '0;
      return 1'b0;
    end
    if (depth == 0) begin
      rep.status = STATUS_UNDERFLOW;
      return 1'b1;
    end
    // inclusive duration; an end before the start counts as zero
    if (ts < frame_start[depth-1]) begin
      dur = '0;
    end else if (ts - frame_start[depth-1] == TIME_MAX) begin
      dur = TIME_MAX;
    end else begin
      dur = ts - frame_start[depth-1] + 1;
    end
    excl = (child_time[depth] > dur) ? '0 : dur - child_time[depth];
    excl_total[id] = sat_sum(excl_total[id], excl);
    rep.total = excl_total[id];
    depth--;
    child_time[depth] = sat_sum(child_time[depth], dur);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    profile_report_t seen;
    profile_report_t due;
    if (!rst_ni) begin
      func_count = FCOUNT_RESET;
      depth = 0;
      foreach (frame_start[i]) frame_start[i] = '0;
      foreach (child_time[i]) child_time[i] = '0;
      foreach (excl_total[i]) excl_total[i] = '0;
      owed_reports.delete();
      fail_count_o = 0;
      owed_count_o <= 0;
    end else begin
      // results first: a result can never belong to an event accepted on the same edge
      if (m_axis_tvalid && m_axis_tready) begin
        seen.func   = m_axis_tdata[ID_WIDTH-1:0];
        seen.total  = m_axis_tdata[ID_WIDTH +: TIME_WIDTH];
        seen.status = status_e'(m_axis_tuser);
        if (owed_reports.size() == 0) begin
          $error("result_func: no report pending, actual %0d (total %0h, status %0d)",
                 seen.func, seen.total, seen.status);
          fail_count_o++;
        end else begin
          due = owed_reports.pop_front();
          if (seen.func !== due.func) begin
            $error("result_func mismatch: expected %0d, actual %0d", due.func, seen.func);
            fail_count_o++;
          end
          if (seen.total !== due.total) begin
            $error("exclusive_total mismatch: expected %0h, actual %0h", due.total, seen.total);
            fail_count_o++;
          end
          if (seen.status !== due.status) begin
            $error("status mismatch: expected %0d, actual %0d", due.status, seen.status);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (account_event(event_kind_e'(s_axis_tuser[0]), s_axis_tdata[ID_WIDTH-1:0],
                          s_axis_tdata[ID_WIDTH +: TIME_WIDTH], due)) begin
          owed_reports.push_back(due);
        end
      end
      if (cfg_we_i) begin
        func_count = cfg_wdata_i;
      end
      owed_count_o <= owed_reports.size();
    end
  end

endmodule

// ----- tb/call_stack_exclusive_time_test.sv -----
// Top of the call_stack_exclusive_time testbench: clock, reset, event stimulus, result sink
// and verdict. Checking lives in call_stack_exclusive_time_checker.
// Depends on cset_pkg, cset_tb_pkg, the checker and the RTL.
module call_stack_exclusive_time_test;
  import cset_pkg::*;
  import cset_tb_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_GAP       = 12;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CNT_WIDTH-1:0]   cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_WIDTH-1:0] s_axis_tdata;   // [5:0] func_id, [37:6] timestamp, pad
  logic [0:0]             s_axis_tuser;   // [0] kind
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_WIDTH-1:0] m_axis_tdata;   // [5:0] result_func, [37:6] exclusive_total
  logic [1:0]             m_axis_tuser;   // [1:0] status

  int fail_count;
  int owed_count;
  int cycle_count;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_token      = 0;

  // stimulus-side view of the stack, used only to shape the event mix
  logic [ID_WIDTH-1:0]   open_frames [$];
  logic [CNT_WIDTH-1:0]  fcount_now;
  logic [TIME_WIDTH-1:0] trace_clock;
  int                    target_depth;
  int                    segment_left;

  call_stack_exclusive_time dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  call_stack_exclusive_time_checker profile_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .owed_count_o  (owed_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("call_stack_exclusive_time verification failed");
    $finish;
  end

  // result sink: random stalls, plus a long hold-off whenever hold_token moves
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_function_count(input logic [CNT_WIDTH-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    fcount_now  = value;
  endtask

  task automatic send_event(input event_kind_e kind, input logic [ID_WIDTH-1:0] id,
                            input logic [TIME_WIDTH-1:0] ts);
    int gap;
    gap = 0;
    while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct && gap < MAX_GAP)
      gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TDATA_WIDTH-ID_WIDTH-TIME_WIDTH){1'b0}}, ts, id};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    if (int'(id) < int'(fcount_now)) begin
      if (kind == EV_ENTER && open_frames.size() < DEF_STACK_DEPTH) begin
        open_frames.push_back(id);
      end else if (kind == EV_EXIT && open_frames.size() > 0) begin
        void'(open_frames.pop_back());
      end
    end
  endtask

  task automatic send_random_event();
    int                    lim;
    int                    roll;
    bit                    go_deeper;
    event_kind_e           kind;
    logic [ID_WIDTH-1:0]   id;
    logic [TIME_WIDTH-1:0] ts;
    lim = (fcount_now < DEF_MAX_FUNCS) ? int'(fcount_now) : DEF_MAX_FUNCS;
    if (segment_left == 0) begin
      target_depth = ($urandom_range(0, 7) == 0) ? DEF_STACK_DEPTH + 8 : $urandom_range(0, 10);
      segment_left = (target_depth > DEF_STACK_DEPTH) ? 160 : 40;
    end
    segment_left--;
    roll = $urandom_range(0, 99);
    if (roll < 3) trace_clock = $urandom();
    else trace_clock = trace_clock + $urandom_range(0, 24);
    ts = ($urandom_range(0, 49) == 0) ? $urandom() : trace_clock;
    go_deeper = (open_frames.size() < target_depth) ? ($urandom_range(0, 3) != 0)
                                                    : ($urandom_range(0, 3) == 0);
    if (roll >= 95 || lim == 0) begin
      // noise: any id, any kind
      kind = event_kind_e'($urandom_range(0, 1));
      id   = ID_WIDTH'($urandom_range(0, DEF_MAX_FUNCS - 1));
    end else if (go_deeper) begin
      kind = EV_ENTER;
      id   = ID_WIDTH'($urandom_range(0, lim - 1));
    end else begin
      kind = EV_EXIT;
      id   = (open_frames.size() > 0 && $urandom_range(0, 6) != 0)
             ? open_frames[$] : ID_WIDTH'($urandom_range(0, lim - 1));
    end
    send_event(kind, id, ts);
  endtask

  // drop valid, wait for every owed report, then let an in-flight enter finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (owed_count != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [CNT_WIDTH-1:0] count, input int send_pct,
                           input int stall_pct, input int n_events, input bit deep_dive,
                           input bit hold_off);
    settle();
    write_function_count(count);
    sender_idle_pct = send_pct;
    recv_stall_pct  = stall_pct;
    if (deep_dive) begin
      target_depth = DEF_STACK_DEPTH + 8;
      segment_left = 160;
    end
    for (int i = 0; i < n_events; i++) begin
      if (hold_off && i == n_events / 4) hold_token++;
      send_random_event();
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    fcount_now   = FCOUNT_RESET;
    trace_clock  = '0;
    target_depth = 0;
    segment_left = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // clearing pass over the totals memory
    repeat (DEF_MAX_FUNCS + 8) @(posedge clk_i);

    write_function_count(7'd40);
    send_event(EV_EXIT,  6'd5,  32'd0);           // underflow on an empty stack
    send_event(EV_ENTER, 6'd63, 32'd0);           // id out of range
    send_event(EV_EXIT,  6'd40, 32'd0);           // id equal to the count
    send_event(EV_ENTER, 6'd0,  32'h0000_0000);
    send_event(EV_EXIT,  6'd0,  32'hFFFF_FFFF);   // full-range duration
    send_event(EV_ENTER, 6'd1,  32'hFFFF_FFFF);
    send_event(EV_EXIT,  6'd1,  32'h0000_0000);   // end before start
    send_event(EV_ENTER, 6'd2,  32'd100);
    send_event(EV_ENTER, 6'd3,  32'd110);
    send_event(EV_EXIT,  6'd3,  32'd119);
    send_event(EV_EXIT,  6'd2,  32'd199);
    send_event(EV_ENTER, 6'd4,  32'd500);
    send_event(EV_EXIT,  6'd5,  32'd509);         // exit id differs from the opener
    send_event(EV_ENTER, 6'd0,  32'd1000);
    send_event(EV_EXIT,  6'd0,  32'd1009);        // total already at max
    send_event(EV_ENTER, 6'd6,  32'd0);
    send_event(EV_ENTER, 6'd7,  32'd0);
    send_event(EV_EXIT,  6'd7,  32'hFFFF_FFFF);
    send_event(EV_EXIT,  6'd6,  32'd5);           // child time above duration
    send_event(EV_ENTER, 6'd9,  32'd0);
    send_event(EV_ENTER, 6'd10, 32'h8000_0000);
    send_event(EV_EXIT,  6'd10, 32'hFFFF_FFFF);
    send_event(EV_ENTER, 6'd11, 32'h0000_0010);
    send_event(EV_EXIT,  6'd11, 32'hFFFF_FFFE);   // parent child sum saturates
    send_event(EV_EXIT,  6'd9,  32'hFFFF_FFFF);

    run_phase(7'd64,  0,  0,  220, 1'b0, 1'b0);
    run_phase(7'd1,   64, 0,  120, 1'b0, 1'b0);
    run_phase(7'd127, 0,  64, 220, 1'b1, 1'b0);
    run_phase(7'd0,   24, 24, 60,  1'b0, 1'b0);
    run_phase(CNT_WIDTH'($urandom_range(2, 63)), 0, 0, 230, 1'b0, 1'b1);
    run_phase(7'd64,  24, 24, 200, 1'b1, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("call_stack_exclusive_time verification clean");
    end else begin
      $display("call_stack_exclusive_time verification failed");
    end
    $finish;
  end

endmodule
